[sv/mth_pkg.sv]
package mth_pkg;

  // transport packet types
  localparam logic [7:0] TYPE_MARKER = 8'h21;
  localparam logic [7:0] TYPE_ANSWER = 8'h41;
  localparam logic [7:0] TYPE_END    = 8'h81;
  localparam logic [7:0] TYPE_ERROR  = 8'h11;

  // reset values of the configuration registers
  localparam logic [7:0]  OWN_ID_RST  = 8'd0;
  localparam logic [7:0]  PEER_ID_RST = 8'd1;
  localparam logic [31:0] TIMEOUT_RST = 32'd1000;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2,
    PH_D = 2'd3
  } mth_phase_t;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_PKT   = 2'd1,
    FN_TICK  = 2'd2,
    FN_NONE  = 2'd3
  } mth_func_t;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_REFUSED = 2'd3
  } mth_status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OWN_ID  = 2'd0,
    REG_PEER_ID = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_UNUSED  = 2'd3
  } mth_reg_t;

endpackage

[sv/marker_transport_handshake.sv]
// Sender side of a four-phase marker-passing handshake between two cores. Each input
// transfer carries a function code in in_tuser (start, received packet or time tick) and
// the received packet's header in in_tdata; each one yields exactly one output transfer
// telling whether a packet is to be sent (out_tuser) with its header and a status code.
// Packets not addressed from peer_id to own_id, or with a non-zero control sum, are
// dropped but still restart the retry timer. Ticks during an active transfer count up
// and resend the last packet once the count exceeds retry_timeout. Throughput is one
// transfer per clock while the skid register is empty: the whole step is a table lookup
// plus one 32-bit increment and compare, and a two-entry output buffer (result plus skid
// register) keeps in_tready registered and lets input run on while output stalls.
// Configuration registers are meant to be written only while no transfer is in flight.
module marker_transport_handshake (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mth_pkg::IN_DATA_W-1:0]     in_tdata,   // pkt_type, pkt_from, pkt_dest, pkt_check
  input  logic [mth_pkg::IN_USER_W-1:0]     in_tuser,   // func
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mth_pkg::OUT_DATA_W-1:0]    out_tdata,  // send_type, send_count, send_from,
                                                        // send_dest, status, zero pad
  output logic [mth_pkg::OUT_USER_W-1:0]    out_tuser,  // send_valid
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [mth_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [mth_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration
  logic [7:0]  own_id_r;
  logic [7:0]  peer_id_r;
  logic [31:0] timeout_r;

  // protocol state
  mth_pkg::mth_phase_t phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] timer_r, timer_nxt;
  logic [7:0]  last_type_r, last_type_nxt;

  // unpacked input fields
  mth_pkg::mth_func_t func;
  logic [7:0]  pkt_type;
  logic [7:0]  pkt_from;
  logic [7:0]  pkt_dest;
  logic [23:0] pkt_check;

  // step result
  logic                  res_send;
  logic [7:0]            res_type;
  mth_pkg::mth_status_t  res_status;
  logic [mth_pkg::OUT_DATA_W-1:0] res_data;
  logic [31:0]           timer_inc;
  logic                  addr_ok;

  // output buffer
  logic                             out_vld_r, skid_vld_r;
  logic [mth_pkg::OUT_DATA_W-1:0]   out_data_r, skid_data_r;
  logic                             out_send_r, skid_send_r;
  logic                             in_fire, out_fire;

  assign func      = mth_pkg::mth_func_t'(in_tuser);
  assign pkt_type  = in_tdata[7:0];
  assign pkt_from  = in_tdata[15:8];
  assign pkt_dest  = in_tdata[23:16];
  assign pkt_check = in_tdata[47:24];

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r  <= mth_pkg::OWN_ID_RST;
      peer_id_r <= mth_pkg::PEER_ID_RST;
      timeout_r <= mth_pkg::TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (mth_pkg::mth_reg_t'(cfg_addr))
        mth_pkg::REG_OWN_ID:  own_id_r  <= cfg_wdata[7:0];
        mth_pkg::REG_PEER_ID: peer_id_r <= cfg_wdata[7:0];
        mth_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign addr_ok   = (pkt_dest == own_id_r) && (pkt_from == peer_id_r) && (pkt_check == '0);
  // saturating tick count
  assign timer_inc = (timer_r == '1) ? timer_r : timer_r + 32'd1;

  // one protocol step
  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    timer_nxt     = timer_r;
    last_type_nxt = last_type_r;
    res_send      = 1'b0;
    res_type      = '0;
    res_status    = mth_pkg::ST_BUSY;

    case (func)
      mth_pkg::FN_START: begin
        if (phase_r != mth_pkg::PH_A) begin
          res_status = mth_pkg::ST_REFUSED;
        end else begin
          count_nxt = count_r + 32'd1;
          phase_nxt = mth_pkg::PH_B;
          res_send  = 1'b1;
          res_type  = mth_pkg::TYPE_MARKER;
        end
      end
      mth_pkg::FN_PKT: begin
        if (phase_r != mth_pkg::PH_A) begin
          // any packet while active restarts the timer
          timer_nxt = '0;
          if (addr_ok) begin
            case (phase_r)
              mth_pkg::PH_B: begin
                case (pkt_type)
                  mth_pkg::TYPE_ANSWER: begin
                    phase_nxt = mth_pkg::PH_C;
                    res_send  = 1'b1;
                    res_type  = mth_pkg::TYPE_END;
                  end
                  mth_pkg::TYPE_MARKER, mth_pkg::TYPE_END: begin
                    res_send = 1'b1;
                    res_type = mth_pkg::TYPE_ERROR;
                  end
                  mth_pkg::TYPE_ERROR: begin
                    res_send = 1'b1;
                    res_type = mth_pkg::TYPE_ANSWER;
                  end
                  default: begin
                    phase_nxt  = mth_pkg::PH_A;
                    res_status = mth_pkg::ST_ERROR;
                  end
                endcase
              end
              mth_pkg::PH_C: begin
                case (pkt_type)
                  mth_pkg::TYPE_MARKER: begin
                    phase_nxt = mth_pkg::PH_D;
                    res_send  = 1'b1;
                    res_type  = mth_pkg::TYPE_ANSWER;
                  end
                  mth_pkg::TYPE_ANSWER: begin
                    res_send = 1'b1;
                    res_type = mth_pkg::TYPE_END;
                  end
                  mth_pkg::TYPE_END: ;  // keep waiting
                  mth_pkg::TYPE_ERROR: begin
                    phase_nxt = mth_pkg::PH_B;
                    res_send  = 1'b1;
                    res_type  = mth_pkg::TYPE_ANSWER;
                  end
                  default: begin
                    phase_nxt  = mth_pkg::PH_A;
                    res_status = mth_pkg::ST_ERROR;
                  end
                endcase
              end
              default: begin  // phase D
                case (pkt_type)
                  mth_pkg::TYPE_MARKER: begin
                    res_send = 1'b1;
                    res_type = mth_pkg::TYPE_ANSWER;
                  end
                  mth_pkg::TYPE_ANSWER, mth_pkg::TYPE_ERROR: begin
                    res_send = 1'b1;
                    res_type = mth_pkg::TYPE_ERROR;
                  end
                  mth_pkg::TYPE_END: begin
                    phase_nxt  = mth_pkg::PH_A;
                    res_status = mth_pkg::ST_DONE;
                  end
                  default: begin
                    phase_nxt  = mth_pkg::PH_A;
                    res_status = mth_pkg::ST_ERROR;
                  end
                endcase
              end
            endcase
          end
        end
      end
      mth_pkg::FN_TICK: begin
        if (phase_r != mth_pkg::PH_A) begin
          timer_nxt = timer_inc;
          if (timer_inc > timeout_r) begin
            res_send = 1'b1;
            res_type = last_type_r;
          end
        end
      end
      default: ;
    endcase

    // every sent packet is remembered for resending and restarts the timer
    if (res_send) begin
      last_type_nxt = res_type;
      timer_nxt     = '0;
    end
  end

  // pack the result, header fields zero when nothing is sent
  always_comb begin
    res_data        = '0;
    res_data[57:56] = res_status;
    if (res_send) begin
      res_data[7:0]   = res_type;
      res_data[39:8]  = count_nxt;
      res_data[47:40] = own_id_r;
      res_data[55:48] = peer_id_r;
    end
  end

  // protocol state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mth_pkg::PH_A;
      count_r     <= '0;
      timer_r     <= '0;
      last_type_r <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      timer_r     <= timer_nxt;
      last_type_r <= last_type_nxt;
    end
  end

  // two-entry output buffer: the skid entry fills only when the result register stalls
  assign in_tready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_fire) begin
          skid_vld_r <= 1'b0;
        end
      end else if (in_fire && out_vld_r && !out_fire) begin
        skid_vld_r <= 1'b1;
      end
      out_vld_r <= skid_vld_r || in_fire || (out_vld_r && !out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
        out_send_r <= skid_send_r;
      end
    end else if (in_fire) begin
      if (!out_vld_r || out_fire) begin
        out_data_r <= res_data;
        out_send_r <= res_send;
      end else begin
        skid_data_r <= res_data;
        skid_send_r <= res_send;
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_send_r;

endmodule

[sv/mth_checker.sv]
module mth_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mth_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [mth_pkg::OUT_USER_W-1:0]    out_tuser
);

  // a stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input is only held off while a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // no packet means empty header fields
  a_no_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[55:0] == '0)
    else $error("header fields set without a packet");

  // a sent packet carries status in progress and a known type
  a_send_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[57:56] == mth_pkg::ST_BUSY &&
      (out_tdata[7:0] == mth_pkg::TYPE_MARKER || out_tdata[7:0] == mth_pkg::TYPE_ANSWER ||
       out_tdata[7:0] == mth_pkg::TYPE_END || out_tdata[7:0] == mth_pkg::TYPE_ERROR))
    else $error("bad packet type or status on send");

  // the upper pad bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:58] == '0)
    else $error("pad bits set");

endmodule

bind marker_transport_handshake mth_checker u_mth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/sv/tb_top.sv]
module tb_top;
  import mth_pkg::*;

  // one transmitted packet (or the lack of one) plus the status code
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_type;
    logic [31:0] send_count;
    logic [7:0]  send_from;
    logic [7:0]  send_dest;
    mth_status_t status;
  } sent_pkt_t;

  // one input item; pinned rows carry a result read straight off the spec
  typedef struct packed {
    mth_func_t   fn;
    logic [7:0]  ptype;
    logic [7:0]  pfrom;
    logic [7:0]  pdest;
    logic [23:0] pcheck;
    logic        pinned;
    sent_pkt_t   res;
  } probe_row_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;

  localparam sent_pkt_t NO_PKT      = '{1'b0, 8'h00, 32'd0, 8'h00, 8'h00, ST_BUSY};
  localparam sent_pkt_t REFUSED_PKT = '{1'b0, 8'h00, 32'd0, 8'h00, 8'h00, ST_REFUSED};
  localparam sent_pkt_t DONE_PKT    = '{1'b0, 8'h00, 32'd0, 8'h00, 8'h00, ST_DONE};
  localparam sent_pkt_t ABORT_PKT   = '{1'b0, 8'h00, 32'd0, 8'h00, 8'h00, ST_ERROR};

  // directed walk with reset configuration (own 0, peer 1, timeout 1000)
  localparam probe_row_t DIRECTED [25] = '{
    // idle: tick, packet and the spare function code are all ignored
    '{FN_TICK,  8'h00,       8'h00, 8'h00, 24'h000000, 1'b1, NO_PKT},
    '{FN_PKT,   TYPE_ANSWER, 8'h01, 8'h00, 24'h000000, 1'b1, NO_PKT},
    '{FN_NONE,  8'hFF,       8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, NO_PKT},
    // first transaction opens with a marker
    '{FN_START, 8'h00,       8'h00, 8'h00, 24'h000000, 1'b1,
      '{1'b1, TYPE_MARKER, 32'd1, OWN_ID_RST, PEER_ID_RST, ST_BUSY}},
    // start while busy is refused
    '{FN_START, 8'hFF,       8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, REFUSED_PKT},
    '{FN_PKT,   TYPE_ANSWER, 8'h01, 8'h00, 24'h000000, 1'b1,
      '{1'b1, TYPE_END, 32'd1, OWN_ID_RST, PEER_ID_RST, ST_BUSY}},
    // wrong destination, wrong source, non-zero control sum
    '{FN_PKT,   TYPE_MARKER, 8'h01, 8'hFF, 24'h000000, 1'b1, NO_PKT},
    '{FN_PKT,   TYPE_MARKER, 8'hFF, 8'h00, 24'h000000, 1'b1, NO_PKT},
    '{FN_PKT,   TYPE_MARKER, 8'h01, 8'h00, 24'hFFFFFF, 1'b1, NO_PKT},
    // phase C and D answers
    '{FN_PKT,   TYPE_END,    8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_TICK,  8'h00,       8'h00, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ANSWER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_MARKER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_MARKER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ANSWER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ERROR,  8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_END,    8'h01, 8'h00, 24'h000000, 1'b1, DONE_PKT},
    // second transaction: every answer out of phase B, then error back from C
    '{FN_START, 8'h00,       8'h00, 8'h00, 24'h000000, 1'b1,
      '{1'b1, TYPE_MARKER, 32'd2, OWN_ID_RST, PEER_ID_RST, ST_BUSY}},
    '{FN_PKT,   TYPE_MARKER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_END,    8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ERROR,  8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ANSWER, 8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    '{FN_PKT,   TYPE_ERROR,  8'h01, 8'h00, 24'h000000, 1'b0, NO_PKT},
    // unknown type aborts to idle, and a fresh start works again
    '{FN_PKT,   8'hFF,       8'h01, 8'h00, 24'h000000, 1'b1, ABORT_PKT},
    '{FN_START, 8'h00,       8'h00, 8'h00, 24'h000000, 1'b1,
      '{1'b1, TYPE_MARKER, 32'd3, OWN_ID_RST, PEER_ID_RST, ST_BUSY}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // pkt_type, pkt_from, pkt_dest, pkt_check
  logic [IN_USER_W-1:0]  in_tuser;   // func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // send_type, send_count, send_from, send_dest, status, pad
  logic [OUT_USER_W-1:0] out_tuser;  // send_valid
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  marker_transport_handshake dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow copy of the handshake state and the registers, reset values
  mth_phase_t  hs_phase     = PH_A;
  logic [31:0] hs_txn_count = 32'd0;
  logic [31:0] hs_wait      = 32'd0;
  logic [7:0]  hs_last_type = 8'h00;
  logic [7:0]  own_id_q     = OWN_ID_RST;
  logic [7:0]  peer_id_q    = PEER_ID_RST;
  logic [31:0] timeout_q    = TIMEOUT_RST;

  sent_pkt_t   awaited_pkts [$];   // results still owed by the block, oldest first
  probe_row_t  offered_items [$];  // items put on the input bus, not yet taken
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // knobs set by the stimulus thread, the stall ones read by the receiver
  bit tx_gap_on     = 1'b1;
  bit rx_stall_on   = 1'b1;
  bit long_hold_req = 1'b0;

  // advance the handshake by one input item and return what it sends
  function automatic sent_pkt_t handshake_step(mth_func_t fn, logic [7:0] ptype,
                                               logic [7:0] pfrom, logic [7:0] pdest,
                                               logic [23:0] pcheck);
    sent_pkt_t  r;
    logic       tx;
    logic       bad_type;
    logic [7:0] tx_type;
    r        = NO_PKT;
    tx       = 1'b0;
    bad_type = 1'b0;
    tx_type  = 8'h00;
    case (fn)
      FN_START: begin
        if (hs_phase != PH_A) begin
          r.status = ST_REFUSED;
        end else begin
          hs_txn_count = hs_txn_count + 32'd1;
          hs_phase     = PH_B;
          tx           = 1'b1;
          tx_type      = TYPE_MARKER;
        end
      end
      FN_PKT: begin
        if (hs_phase != PH_A) begin
          // every packet restarts the timer, even a dropped one
          hs_wait = 32'd0;
          if (pdest == own_id_q && pfrom == peer_id_q && pcheck == 24'd0) begin
            case (hs_phase)
              PH_B: begin
                case (ptype)
                  TYPE_ANSWER: begin hs_phase = PH_C; tx = 1'b1; tx_type = TYPE_END; end
                  TYPE_MARKER, TYPE_END: begin tx = 1'b1; tx_type = TYPE_ERROR; end
                  TYPE_ERROR: begin tx = 1'b1; tx_type = TYPE_ANSWER; end
                  default: bad_type = 1'b1;
                endcase
              end
              PH_C: begin
                case (ptype)
                  TYPE_MARKER: begin hs_phase = PH_D; tx = 1'b1; tx_type = TYPE_ANSWER; end
                  TYPE_ANSWER: begin tx = 1'b1; tx_type = TYPE_END; end
                  TYPE_END: ;  // keep waiting
                  TYPE_ERROR: begin hs_phase = PH_B; tx = 1'b1; tx_type = TYPE_ANSWER; end
                  default: bad_type = 1'b1;
                endcase
              end
              default: begin
                case (ptype)
                  TYPE_MARKER: begin tx = 1'b1; tx_type = TYPE_ANSWER; end
                  TYPE_ANSWER, TYPE_ERROR: begin tx = 1'b1; tx_type = TYPE_ERROR; end
                  TYPE_END: begin hs_phase = PH_A; r.status = ST_DONE; end
                  default: bad_type = 1'b1;
                endcase
              end
            endcase
            if (bad_type) begin
              hs_phase = PH_A;
              r.status = ST_ERROR;
            end
          end
        end
      end
      FN_TICK: begin
        if (hs_phase != PH_A) begin
          if (hs_wait != 32'hFFFF_FFFF) hs_wait = hs_wait + 32'd1;
          if (hs_wait > timeout_q) begin
            tx      = 1'b1;
            tx_type = hs_last_type;
          end
        end
      end
      default: ;
    endcase
    if (tx) begin
      hs_last_type = tx_type;
      hs_wait      = 32'd0;
      r.send_valid = 1'b1;
      r.send_type  = tx_type;
      r.send_count = hs_txn_count;
      r.send_from  = own_id_q;
      r.send_dest  = peer_id_q;
    end
    return r;
  endfunction

  // the type that moves a transaction on from the current phase
  function automatic logic [7:0] forward_type();
    case (hs_phase)
      PH_B:    return TYPE_ANSWER;
      PH_C:    return TYPE_MARKER;
      PH_D:    return TYPE_END;
      default: return TYPE_MARKER;
    endcase
  endfunction

  function automatic logic [7:0] known_type(int unsigned k);
    case (k)
      0:       return TYPE_MARKER;
      1:       return TYPE_ANSWER;
      2:       return TYPE_END;
      default: return TYPE_ERROR;
    endcase
  endfunction

  // mostly well-formed packets steering the handshake on, with ticks,
  // refused starts, spoilt headers, unknown types and the spare code mixed in
  function automatic probe_row_t random_row();
    probe_row_t  row;
    int unsigned pick;
    row.fn     = FN_PKT;
    row.ptype  = 8'($urandom);
    row.pfrom  = 8'($urandom);
    row.pdest  = 8'($urandom);
    row.pcheck = 24'($urandom);
    row.pinned = 1'b0;
    row.res    = NO_PKT;
    pick = $urandom_range(0, 99);
    if (hs_phase == PH_A && pick < 70) pick = 0;
    if (pick < 12) begin
      row.fn = FN_START;
    end else if (pick < 80 && pick >= 45) begin
      row.fn = FN_TICK;
    end else if (pick < 95) begin
      row.pfrom  = peer_id_q;
      row.pdest  = own_id_q;
      row.pcheck = 24'd0;
      if (pick < 45) begin
        row.ptype = ($urandom_range(0, 2) == 0) ? known_type($urandom_range(0, 3))
                                                : forward_type();
      end else if (pick < 88) begin
        // spoil exactly one header field
        case ($urandom_range(0, 2))
          0:       row.pdest  = own_id_q ^ 8'($urandom_range(1, 255));
          1:       row.pfrom  = peer_id_q ^ 8'($urandom_range(1, 255));
          default: row.pcheck = 24'($urandom_range(1, 24'hFF_FFFF));
        endcase
      end
    end else begin
      row.fn = FN_NONE;
    end
    return row;
  endfunction

  // 10 time unit clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // put one item on the input bus and hold it until the block takes it
  task automatic offer_item(probe_row_t row);
    if (tx_gap_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= row.fn;
    in_tdata  <= {row.pcheck, row.pdest, row.pfrom, row.ptype};
    offered_items.push_back(row);
    do @(posedge clk); while (!in_tready);
  endtask

  // random items until n of them have done something besides being ignored
  task automatic run_random(int unsigned n);
    probe_row_t  row;
    int unsigned effective;
    effective = 0;
    while (effective < n) begin
      row = random_row();
      if (row.fn != FN_NONE && (row.fn == FN_START || hs_phase != PH_A))
        effective++;
      offer_item(row);
    end
  endtask

  // release the bus and wait until every result is back
  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_pkts.size() != 0 || offered_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back writes of all three registers, block idle
  task automatic set_config(logic [7:0] own, logic [7:0] peer, logic [31:0] tmo);
    mth_reg_t    idx;
    logic [31:0] val;
    for (int i = 0; i < 3; i++) begin
      idx = mth_reg_t'(i);
      case (idx)
        REG_OWN_ID:  val = {24'd0, own};
        REG_PEER_ID: val = {24'd0, peer};
        default:     val = tmo;
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      case (idx)
        REG_OWN_ID:  own_id_q  = val[7:0];
        REG_PEER_ID: peer_id_q = val[7:0];
        REG_TIMEOUT: timeout_q = val;
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic compare_result(sent_pkt_t want, sent_pkt_t got, logic [5:0] pad);
    if (got.send_valid !== want.send_valid) begin
      $error("send_valid: expected %0d, got %0d", want.send_valid, got.send_valid);
      fail_count++;
    end
    if (got.send_type !== want.send_type) begin
      $error("send_type: expected %0h, got %0h", want.send_type, got.send_type);
      fail_count++;
    end
    if (got.send_count !== want.send_count) begin
      $error("send_count: expected %0d, got %0d", want.send_count, got.send_count);
      fail_count++;
    end
    if (got.send_from !== want.send_from) begin
      $error("send_from: expected %0h, got %0h", want.send_from, got.send_from);
      fail_count++;
    end
    if (got.send_dest !== want.send_dest) begin
      $error("send_dest: expected %0h, got %0h", want.send_dest, got.send_dest);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (pad !== 6'd0) begin
      $error("pad: expected 0, got %0h", pad);
      fail_count++;
    end
  endtask

  // sample both buses at the rising edge; results are checked before the
  // item taken on the same edge is predicted, so a combinational result fails
  always @(posedge clk) begin : bus_monitor
    sent_pkt_t  got;
    sent_pkt_t  want;
    probe_row_t row;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.send_valid = out_tuser[0];
        got.send_type  = out_tdata[7:0];
        got.send_count = out_tdata[39:8];
        got.send_from  = out_tdata[47:40];
        got.send_dest  = out_tdata[55:48];
        got.status     = mth_status_t'(out_tdata[57:56]);
        if (awaited_pkts.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fail_count++;
        end else begin
          want = awaited_pkts.pop_front();
          compare_result(want, got, out_tdata[63:58]);
        end
      end
      if (in_tvalid && in_tready) begin
        row  = offered_items.pop_front();
        want = handshake_step(mth_func_t'(in_tuser), in_tdata[7:0], in_tdata[15:8],
                              in_tdata[23:16], in_tdata[47:24]);
        // pinned rows use the hand-written result, the shadow state still moves on
        awaited_pkts.push_back(row.pinned ? row.res : want);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // receiver: short random stalls, and on request one long hold-off that
  // backs the block up until it stops taking input
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready <= 1'b1;
      end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transfer on either bus
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [7:0] same_id;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk under the reset configuration
    for (int i = 0; i < 25; i++) offer_item(DIRECTED[i]);
    wait_quiet();

    // extreme identifiers, timeout of 1: resends on two quiet ticks
    set_config(8'hFF, 8'h00, 32'd1);
    run_random(115);
    wait_quiet();

    // sender keeps offering while the receiver holds off for a long stretch
    set_config(8'($urandom), 8'($urandom), 32'd3);
    tx_gap_on     = 1'b0;
    long_hold_req = 1'b1;
    run_random(115);
    tx_gap_on = 1'b1;
    wait_quiet();

    // own and peer identical, maximum timeout never resends
    same_id = 8'($urandom);
    set_config(same_id, same_id, 32'hFFFF_FFFF);
    run_random(115);
    wait_quiet();

    set_config(8'($urandom), 8'($urandom), 32'($urandom_range(1, 8)));
    run_random(115);
    wait_quiet();

    // last stretch at full rate on both sides
    tx_gap_on   = 1'b0;
    rx_stall_on = 1'b0;
    set_config(8'h00, 8'hFF, 32'd2);
    run_random(115);
    wait_quiet();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mth_pkg.sv
sv/marker_transport_handshake.sv
sv/mth_checker.sv
tb/sv/tb_top.sv
